### rtl/srb_pkg.sv
// Package for the stack-ended queue: opcode, status and cell command types.
// Used by srb_cell, steque_ring_buffer and srb_checker; depends on nothing.
`timescale 1ns / 1ps

package srb_pkg;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2,
        OP_NOP  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_ZERO  = 2'd3
    } status_t;

    // What every cell of the row does in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,
        CELL_SHIFT_OUT,
        CELL_LOAD_TAIL
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      tail_hit;
    } cell_ctrl_t;

endpackage

### rtl/srb_cell.sv
// One storage cell of the steque row: holds one word and trades it with its neighbours.
// Depends on srb_pkg for the cell control struct.
`timescale 1ns / 1ps

module srb_cell
    import srb_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [DATA_WIDTH-1:0] new_word,
    output logic [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.cmd)
            CELL_HOLD:      data_next = data_reg;
            CELL_SHIFT_IN:  data_next = left_data;
            CELL_SHIFT_OUT: data_next = right_data;
            CELL_LOAD_TAIL:
            begin
                if (ctrl.tail_hit)
                begin
                    data_next = new_word;
                end
            end
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/steque_ring_buffer.sv
// Top level of the stack-ended queue: a row of srb_cell word cells with the head in cell 0.
// Depends on srb_pkg and srb_cell.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       to block   in_valid / in_ready       opcode, value
// out      from block out_valid / out_ready     popped_value, status, is_empty, occupancy
//
// Each transfer in produces one registered result in the next cycle; an item is taken every cycle
// while the output register is empty or is being drained in the same cycle.
// Push shifts the whole row one cell towards the tail, pop shifts it towards the head
// and enqueue loads the cell picked by the entry count.
// Reset empties the queue at once; cell contents are not cleared.
// A stalled result holds the input side off until out_ready is seen.

module steque_ring_buffer
    import srb_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 64,
    localparam int OCC_W     = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       opcode,
    input  logic [63:0]      value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [63:0]      popped_value,
    output logic [1:0]       status,
    output logic             is_empty,
    output logic [OCC_W-1:0] occupancy
);

    logic                  accept;
    logic [DATA_WIDTH-1:0] new_word;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    cell_cmd_t             cmd;

    logic [OCC_W-1:0] count_reg;
    logic [OCC_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [63:0]      popped_reg;
    logic [63:0]      popped_next;
    status_t          status_reg;
    status_t          status_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign new_word = value[DATA_WIDTH-1:0];

    always_comb
    begin
        cmd         = CELL_HOLD;
        count_next  = count_reg;
        popped_next = '0;
        status_next = ST_OK;
        if (accept)
        begin
            unique case (opcode_t'(opcode))
                OP_ENQ, OP_PUSH:
                begin
                    if (new_word == '0)
                    begin
                        status_next = ST_ZERO;
                    end
                    else if (count_reg == OCC_W'(DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd        = (opcode_t'(opcode) == OP_ENQ) ? CELL_LOAD_TAIL
                                                                    : CELL_SHIFT_IN;
                        count_next = count_reg + OCC_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd         = CELL_SHIFT_OUT;
                        popped_next = 64'(cell_data[0]);
                        count_next  = count_reg - OCC_W'(1);
                    end
                end
                OP_NOP:
                begin
                    status_next = ST_OK;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
    end

    // The row of cells: cell 0 is the head, the tail sits at the entry count.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t            ctrl;
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        assign ctrl.cmd      = cmd;
        assign ctrl.tail_hit = (count_reg == OCC_W'(i));

        if (i == 0)
        begin : g_first
            assign left_data = new_word;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        srb_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .left_data (left_data),
            .right_data(right_data),
            .new_word  (new_word),
            .data      (cell_data[i])
        );
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign is_empty     = (count_reg == '0);
    assign occupancy    = count_reg;

endmodule

### rtl/srb_checker.sv
// Port-level checker for steque_ring_buffer, attached by the bind at the end of this file.
// Depends on srb_pkg for the status codes.
`timescale 1ns / 1ps

module srb_checker
    import srb_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int OCC_W = 5
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [63:0]      popped_value,
    input logic [1:0]       status,
    input logic             is_empty,
    input logic [OCC_W-1:0] occupancy
);

    // A result that is not taken must stay on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(popped_value) && $stable(status))
        else $error("result changed while stalled");

    // With no result waiting the block must take a new item.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output register");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> is_empty && (popped_value == '0))
        else $error("pop on empty reported a value or entries");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (occupancy == OCC_W'(DEPTH)))
        else $error("full rejection while space was left");

endmodule

bind steque_ring_buffer srb_checker #(
    .DEPTH(DEPTH),
    .OCC_W(OCC_W)
) u_srb_checker (.*);

### verif/tb_top.sv
// Self-checking testbench for the steque_ring_buffer stack-ended queue.
// Depends on srb_pkg and the RTL; keeps its own ring model to predict every result.
`timescale 1ns / 1ps

module tb_top;
    import srb_pkg::*;

    localparam int DEPTH = 16;

    typedef struct {
        logic [63:0] popped;
        status_t     st;
        logic        empty;
        logic [4:0]  occ;
    } steque_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [63:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] popped_value;
    logic [1:0]  status;
    logic        is_empty;
    logic [4:0]  occupancy;

    // Our own copy of the ring and its pointers.
    logic [63:0] ring_words [DEPTH];
    int          head_slot;
    int          tail_slot;
    int          held_count;

    steque_result_t awaited_results[$];
    int             mismatch_count;
    int             hold_cycles;
    bit             src_eager;
    bit             snk_eager;

    steque_ring_buffer #(.DEPTH(DEPTH), .DATA_WIDTH(64)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .status       (status),
        .is_empty     (is_empty),
        .occupancy    (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #800000;
        $display("status: fail");
        $finish;
    end

    function automatic steque_result_t steque_predict(input opcode_t op,
                                                      input logic [63:0] val);
        steque_result_t r;
        r.popped = '0;
        r.st     = ST_OK;
        if (op == OP_ENQ || op == OP_PUSH)
        begin
            if (val == '0)
                r.st = ST_ZERO;
            else if (held_count >= DEPTH)
                r.st = ST_FULL;
            else if (op == OP_ENQ)
            begin
                ring_words[tail_slot] = val;
                tail_slot = (tail_slot + 1) % DEPTH;
                held_count++;
            end
            else
            begin
                head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
                ring_words[head_slot] = val;
                held_count++;
            end
        end
        else if (op == OP_POP)
        begin
            if (held_count == 0)
                r.st = ST_EMPTY;
            else
            begin
                r.popped = ring_words[head_slot];
                head_slot = (head_slot + 1) % DEPTH;
                held_count--;
            end
        end
        r.empty = (held_count == 0);
        r.occ   = held_count[4:0];
        return r;
    endfunction

    function automatic logic [63:0] any_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        else if (pick < 10)
            return '1;
        else if (pick < 15)
            return 64'($urandom_range(1, 255));
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] nonzero_value();
        logic [63:0] v;
        do
            v = {$urandom, $urandom};
        while (v == '0);
        return v;
    endfunction

    function automatic opcode_t pick_op(input int enq_w, input int push_w, input int pop_w);
        int roll;
        roll = $urandom_range(0, enq_w + push_w + pop_w + 2);
        if (roll < enq_w)
            return OP_ENQ;
        else if (roll < enq_w + push_w)
            return OP_PUSH;
        else if (roll < enq_w + push_w + pop_w)
            return OP_POP;
        return OP_NOP;
    endfunction

    task automatic log_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s at %0t ns: expected %h, got %h",
                     field, $time, want, got);
    endtask

    task automatic send_op(input opcode_t op, input logic [63:0] val);
        int gap;
        gap = src_eager ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // The transfer happened at this edge, so the model moves on now.
        awaited_results.push_back(steque_predict(op, val));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // Result side: draws a stall per transfer, honours long hold-offs and checks each result.
    initial
    begin : result_sink
        steque_result_t want;
        int             stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                    log_mismatch("unexpected result", '0, popped_value);
                else
                begin
                    want = awaited_results.pop_front();
                    if (popped_value !== want.popped)
                        log_mismatch("popped_value", want.popped, popped_value);
                    if (status !== want.st)
                        log_mismatch("status", 64'(want.st), 64'(status));
                    if (is_empty !== want.empty)
                        log_mismatch("is_empty", 64'(want.empty), 64'(is_empty));
                    if (occupancy !== want.occ)
                        log_mismatch("occupancy", 64'(want.occ), 64'(occupancy));
                end
                stall_left = snk_eager ? 0 : $urandom_range(0, 7);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic test_directed_basics();
        send_op(OP_POP, 64'h0);
        send_op(OP_ENQ, 64'h0);
        send_op(OP_PUSH, 64'h0);
        send_op(OP_NOP, '1);
        send_op(OP_NOP, 64'h0);
        send_op(OP_ENQ, '1);
        send_op(OP_PUSH, 64'h1);
        send_op(OP_ENQ, 64'h8000_0000_0000_0000);
        send_op(OP_PUSH, 64'h5555_5555_5555_5555);
        send_op(OP_ENQ, 64'hAAAA_AAAA_AAAA_AAAA);
        // The value field is meaningless on a pop; drive it hard to be sure.
        send_op(OP_POP, '1);
        send_op(OP_POP, 64'h0);
        send_op(OP_POP, 64'h1234_5678_9ABC_DEF0);
        send_op(OP_POP, 64'h0);
        send_op(OP_POP, 64'h0);
        send_op(OP_POP, 64'h0);
    endtask

    // Fill to capacity, try the full and zero rejections on a full store, then empty it again.
    task automatic test_fill_to_full();
        while (held_count != 0)
            send_op(OP_POP, any_value());
        while (held_count < DEPTH)
            send_op($urandom_range(0, 1) ? OP_ENQ : OP_PUSH, nonzero_value());
        send_op(OP_ENQ, nonzero_value());
        send_op(OP_PUSH, '1);
        // A zero value is refused as zero even when the store is also full.
        send_op(OP_ENQ, 64'h0);
        send_op(OP_NOP, nonzero_value());
        while (held_count != 0)
            send_op(OP_POP, any_value());
        send_op(OP_POP, any_value());
    endtask

    // The receiver holds off for a long stretch while the sender offers back to back.
    task automatic test_output_backpressure();
        src_eager   = 1'b1;
        hold_cycles = 60;
        repeat (24)
            send_op(pick_op(40, 30, 30), any_value());
        src_eager = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_mix();
        int enq_w;
        int push_w;
        int pop_w;
        for (int phase = 0; phase < 9; phase++)
        begin
            case ($urandom_range(0, 3))
                0: begin enq_w = 60; push_w = 15; pop_w = 25; end
                1: begin enq_w = 15; push_w = 60; pop_w = 25; end
                2: begin enq_w = 35; push_w = 35; pop_w = 30; end
                default: begin enq_w = 20; push_w = 20; pop_w = 60; end
            endcase
            src_eager = ($urandom_range(0, 3) == 0);
            snk_eager = ($urandom_range(0, 3) == 0);
            repeat (200)
                send_op(pick_op(enq_w, push_w, pop_w), any_value());
            // Every other phase the sender stops until all results are back.
            if (phase % 2 == 1)
                wait_drained();
        end
        src_eager = 1'b0;
        snk_eager = 1'b0;
    endtask

    initial
    begin
        mismatch_count = 0;
        hold_cycles    = 0;
        src_eager      = 1'b0;
        snk_eager      = 1'b0;
        head_slot      = 0;
        tail_slot      = 0;
        held_count     = 0;
        rst_n          = 1'b0;
        in_valid      <= 1'b0;
        opcode        <= OP_ENQ;
        value         <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_fill_to_full();
        test_output_backpressure();
        test_random_mix();
        test_fill_to_full();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
